// File: rtl/core/rgbconv_pkg.sv
`timescale 1ns / 1ps

package rgbconv_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH      = 2048;
  localparam int DEF_COEF_FRAC_BITS = 12;

  // The kernel never exceeds three by three in this design.
  localparam int MAX_KERNEL = 3;

  // Configuration port.
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_KROWS    = 3'd2,
    REG_KCOLS    = 3'd3,
    REG_COEF_TOP = 3'd4,
    REG_COEF_MID = 3'd5,
    REG_COEF_BOT = 3'd6
  } reg_idx_t;

  localparam logic [11:0] RST_WIDTH    = 12'd1024;
  localparam logic [11:0] RST_HEIGHT   = 12'd768;
  localparam logic [1:0]  RST_KROWS    = 2'd3;
  localparam logic [1:0]  RST_KCOLS    = 2'd3;
  localparam logic [47:0] RST_COEF_TOP = 48'd0;
  localparam logic [47:0] RST_COEF_MID = 48'd268435456;
  localparam logic [47:0] RST_COEF_BOT = 48'd0;

  // Which neighbors of an output position lie inside the image.
  typedef struct packed {
    logic up;
    logic dn;
    logic left;
    logic right;
  } tap_valid_t;

  // Control that travels with one output through the window stage.
  typedef struct packed {
    tap_valid_t valid;
    logic       last;
    logic [1:0] bank;
  } token_t;

endpackage

// File: rtl/core/rgb_image_convolution_top.sv
`timescale 1ns / 1ps
// A result passes the bank read, window and output registers once its item is accepted.
// Throughput: one item per cycle while not stalled, one result per cycle at most.
// Reset (rst, synchronous, active high) restores the register defaults, clears all
// position counters and empties the pipeline; the line banks keep their contents.

module rgb_image_convolution_top #(
  parameter int MAX_WIDTH      = rgbconv_pkg::DEF_MAX_WIDTH,
  parameter int COEF_FRAC_BITS = rgbconv_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [7:0]                       in_blue,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_red,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_blue,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_red,
  output logic                             last_pixel,
  input  logic                             cfg_write,
  input  logic [rgbconv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbconv_pkg::CFG_DAT_W-1:0] cfg_data
);

  import rgbconv_pkg::*;

  // While in_ready is high the block takes one item per cycle, set by the line banks:
  // each image row lives in one of four banks (row modulo four), and every
  // bank is written once and read at two columns (x and x+1) per cycle. The
  // input may run up to two rows ahead of the output row, so four banks keep
  // the row being written apart from the row above the output even when the
  // image is a single column wide. The column left of the output is kept from
  // the previous output, so a whole 3 by 3 window is available for each output
  // without a second pass.
  //
  // Pipeline:
  //   issue  - the accepted item is written to its bank, the emit decision is
  //            made from the position counters, and the reads for
  //            the next output are launched.
  //   window - bank data arrives, the three rows are put in order and every
  //            tap is multiplied by its coefficient.
  //   output - the nine products per channel are summed, rounded to nearest
  //            with ties to even and saturated to 0..255.
  // Each stage holds its item when the stage after it is full, so the block can
  // keep accepting items while a finished result waits, until its stages fill.

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;
  localparam int NW = WW + 12;
  localparam int PW = 25;
  localparam int SW = PW + 4;

  // ---------------------------------------------------------------- registers
  logic [11:0] reg_width;
  logic [11:0] reg_height;
  logic [1:0]  reg_krows;
  logic [1:0]  reg_kcols;
  logic [47:0] coef_row [3];
  logic        cfg_hit;

  assign cfg_hit = cfg_write && (cfg_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width   <= RST_WIDTH;
      reg_height  <= RST_HEIGHT;
      reg_krows   <= RST_KROWS;
      reg_kcols   <= RST_KCOLS;
      coef_row[0] <= RST_COEF_TOP;
      coef_row[1] <= RST_COEF_MID;
      coef_row[2] <= RST_COEF_BOT;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:    reg_width   <= cfg_data[11:0];
        REG_HEIGHT:   reg_height  <= cfg_data[11:0];
        REG_KROWS:    reg_krows   <= cfg_data[1:0];
        REG_KCOLS:    reg_kcols   <= cfg_data[1:0];
        REG_COEF_TOP: coef_row[0] <= cfg_data;
        REG_COEF_MID: coef_row[1] <= cfg_data;
        REG_COEF_BOT: coef_row[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective geometry. Out-of-range register values are clamped.
  logic [31:0]   width_raw;
  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [1:0]    kr_eff;
  logic [1:0]    kc_eff;
  logic [1:0]    kh;
  logic [1:0]    kw;
  logic [NW-1:0] total;
  logic [NW-1:0] lag;

  always_comb begin
    width_raw = 32'(reg_width);
    if (width_raw < 32'd1) begin
      width_raw = 32'd1;
    end
    if (width_raw > 32'(MAX_WIDTH)) begin
      width_raw = 32'(MAX_WIDTH);
    end
    w_eff = WW'(width_raw);
  end

  assign h_eff  = (reg_height == 12'd0) ? 12'd1 : reg_height;
  assign kr_eff = (reg_krows == 2'd0) ? 2'd1 :
                  ((reg_krows > 2'(MAX_KERNEL)) ? 2'(MAX_KERNEL) : reg_krows);
  assign kc_eff = (reg_kcols == 2'd0) ? 2'd1 :
                  ((reg_kcols > 2'(MAX_KERNEL)) ? 2'(MAX_KERNEL) : reg_kcols);
  assign kh     = kr_eff >> 1;
  assign kw     = kc_eff >> 1;
  assign total  = NW'(w_eff) * NW'(h_eff);
  // Rows and columns still missing below and right of the anchor.
  assign lag    = ((kr_eff == 2'd3) ? NW'(w_eff) : NW'(0)) + NW'(kc_eff == 2'd3);

  // Coefficient matrix over the window offsets -1..+1. Taps outside the kernel
  // get a zero coefficient, so the window datapath is always 3 by 3.
  function automatic logic tap_ok(input int i, input logic [1:0] k, input logic [1:0] half);
    int kidx;
    kidx = i + int'(half) - 1;
    return (kidx >= 0) && (kidx < int'(k));
  endfunction

  logic signed [15:0] cm [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (tap_ok(i, kr_eff, kh) && tap_ok(j, kc_eff, kw)) begin
          cm[i][j] = coef_row[2'(i + int'(kh) - 1)][16 * (j + int'(kw) - 1) +: 16];
        end else begin
          cm[i][j] = '0;
        end
      end
    end
  end

  // ------------------------------------------------------------ issue stage
  logic [AW-1:0] in_col, in_col_next;
  logic [1:0]    in_bank, in_bank_next;
  logic [NW-1:0] n_cnt, n_cnt_next;
  logic [AW-1:0] out_col, out_col_next;
  logic [11:0]   out_row, out_row_next;
  logic [1:0]    out_bank, out_bank_next;
  logic [NW-1:0] p_cnt, p_cnt_next;

  logic          accept;
  logic          store;
  logic [NW-1:0] n_after;
  logic          emit;
  logic          emit_last;
  logic          rd_en;
  logic [WW-1:0] in_col_plus;
  logic [WW-1:0] col_plus;
  logic [12:0]   row_plus;

  function automatic logic [1:0] bank_step(input logic [1:0] b);
    return b + 2'd1;
  endfunction

  assign accept      = in_valid && in_ready;
  // Pixels beyond the end of the image are dropped.
  assign store       = !req_type && (n_cnt < total);
  assign n_after     = n_cnt + NW'(store);
  // The next output goes out once every tap it needs has arrived, or once the
  // whole image is in (this is what lets drain items flush the tail).
  assign emit        = (p_cnt < total) && ((n_after >= total) || (n_after > p_cnt + lag));
  assign emit_last   = (p_cnt == total - NW'(1));
  assign rd_en       = accept && emit;
  assign in_col_plus = WW'(in_col) + WW'(1);
  assign col_plus    = WW'(out_col) + WW'(1);
  assign row_plus    = 13'(out_row) + 13'd1;

  always_comb begin
    in_col_next   = in_col;
    in_bank_next  = in_bank;
    n_cnt_next    = n_cnt;
    out_col_next  = out_col;
    out_row_next  = out_row;
    out_bank_next = out_bank;
    p_cnt_next    = p_cnt;
    if (cfg_hit) begin
      // Any register write aborts the current image.
      in_col_next   = '0;
      in_bank_next  = '0;
      n_cnt_next    = '0;
      out_col_next  = '0;
      out_row_next  = '0;
      out_bank_next = '0;
      p_cnt_next    = '0;
    end else if (accept) begin
      if (store) begin
        n_cnt_next = n_after;
        if (in_col_plus >= w_eff) begin
          in_col_next  = '0;
          in_bank_next = bank_step(in_bank);
        end else begin
          in_col_next = in_col_plus[AW-1:0];
        end
      end
      if (emit && emit_last) begin
        // End of image: the next pixel starts a new one.
        in_col_next   = '0;
        in_bank_next  = '0;
        n_cnt_next    = '0;
        out_col_next  = '0;
        out_row_next  = '0;
        out_bank_next = '0;
        p_cnt_next    = '0;
      end else if (emit) begin
        p_cnt_next = p_cnt + NW'(1);
        if (col_plus >= w_eff) begin
          out_col_next  = '0;
          out_row_next  = out_row + 12'd1;
          out_bank_next = bank_step(out_bank);
        end else begin
          out_col_next = col_plus[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_bank  <= '0;
      n_cnt    <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_bank <= '0;
      p_cnt    <= '0;
    end else begin
      in_col   <= in_col_next;
      in_bank  <= in_bank_next;
      n_cnt    <= n_cnt_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      out_bank <= out_bank_next;
      p_cnt    <= p_cnt_next;
    end
  end

  // Line banks: two copies per bank give the two read columns.
  logic [23:0] wr_pixel;
  logic [23:0] rd_c [4];
  logic [23:0] rd_r [4];

  assign wr_pixel = {in_red, in_green, in_blue};

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic bank_we;
    assign bank_we = accept && store && (in_bank == 2'(k));

    rgbconv_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_center (
      .clk   (clk),
      .we    (bank_we),
      .waddr (in_col),
      .wdata (wr_pixel),
      .re    (rd_en),
      .raddr (out_col),
      .rdata (rd_c[k])
    );

    rgbconv_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_right (
      .clk   (clk),
      .we    (bank_we),
      .waddr (in_col),
      .wdata (wr_pixel),
      .re    (rd_en),
      .raddr (col_plus[AW-1:0]),
      .rdata (rd_r[k])
    );
  end

  // ----------------------------------------------------------- window stage
  logic   b_valid;
  token_t b_tok;
  logic   c_valid;
  logic   move_b, move_c, can_c, can_o;

  assign can_o    = !out_valid || out_ready;
  assign move_c   = c_valid && can_o;
  assign can_c    = !c_valid || move_c;
  assign move_b   = b_valid && can_c;
  assign in_ready = !b_valid || can_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rd_en) begin
      b_valid <= 1'b1;
    end else if (move_b) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_tok.valid.up    <= (out_row != 12'd0);
      b_tok.valid.dn    <= (row_plus < 13'(h_eff));
      b_tok.valid.left  <= (out_col != '0);
      b_tok.valid.right <= (col_plus < w_eff);
      b_tok.last        <= emit_last;
      b_tok.bank        <= out_bank;
    end
  end

  // Rows in window order: above, at and below the output row.
  logic [1:0]  row_bank [3];
  logic [23:0] col_mid [3];
  logic [23:0] col_rgt [3];
  logic [23:0] prevc [3];
  logic        row_ok [3];
  logic        col_ok [3];
  logic [23:0] tap_pix;
  logic signed [PW-1:0] prod_next [3][9];
  logic signed [PW-1:0] c_prod [3][9];
  logic                 c_last;

  assign row_bank[0] = b_tok.bank - 2'd1;
  assign row_bank[1] = b_tok.bank;
  assign row_bank[2] = bank_step(b_tok.bank);
  assign row_ok[0]   = b_tok.valid.up;
  assign row_ok[1]   = 1'b1;
  assign row_ok[2]   = b_tok.valid.dn;
  assign col_ok[0]   = b_tok.valid.left;
  assign col_ok[1]   = 1'b1;
  assign col_ok[2]   = b_tok.valid.right;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      col_mid[r] = rd_c[row_bank[r]];
      col_rgt[r] = rd_r[row_bank[r]];
    end
  end

  // Taps outside the image are zero, which is the zero padding. Taps outside
  // the kernel are skipped as well, since their bank entries may not have been
  // written yet.
  always_comb begin
    tap_pix = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (c == 0) begin
          tap_pix = prevc[r];
        end else if (c == 1) begin
          tap_pix = col_mid[r];
        end else begin
          tap_pix = col_rgt[r];
        end
        for (int ch = 0; ch < 3; ch++) begin
          if (row_ok[r] && col_ok[c] && (cm[r][c] != 16'sd0)) begin
            prod_next[ch][r * 3 + c] = PW'(cm[r][c]) *
                                       PW'($signed({1'b0, tap_pix[8 * ch +: 8]}));
          end else begin
            prod_next[ch][r * 3 + c] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (move_b) begin
      c_valid <= 1'b1;
    end else if (move_c) begin
      c_valid <= 1'b0;
    end
  end

  // The center column becomes the left column of the next output in the row.
  always_ff @(posedge clk) begin
    if (move_b) begin
      c_prod <= prod_next;
      c_last <= b_tok.last;
      for (int r = 0; r < 3; r++) begin
        prevc[r] <= col_mid[r];
      end
    end
  end

  // ----------------------------------------------------------- output stage
  function automatic logic [7:0] round_sat(input logic signed [SW-1:0] s);
    logic [SW-1:0]             q;
    logic [COEF_FRAC_BITS-1:0] rem;
    logic                      up;
    q   = SW'($unsigned(s)) >> COEF_FRAC_BITS;
    rem = s[COEF_FRAC_BITS-1:0];
    // Round half to even: above half always, exactly half only on an odd quotient.
    up  = rem[COEF_FRAC_BITS-1] && ((rem[COEF_FRAC_BITS-2:0] != '0) || q[0]);
    q   = q + SW'(up);
    if (s <= 0) begin
      return 8'd0;
    end
    return (q > SW'(255)) ? 8'hFF : q[7:0];
  endfunction

  logic signed [SW-1:0] sum [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int t = 0; t < 9; t++) begin
        sum[ch] = sum[ch] + SW'(c_prod[ch][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_c) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_c) begin
      out_blue   <= round_sat(sum[0]);
      out_green  <= round_sat(sum[1]);
      out_red    <= round_sat(sum[2]);
      last_pixel <= c_last;
    end
  end

  // --------------------------------------------------------------- checks
  // An output can never run ahead of the pixels received.
  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    p_cnt <= n_cnt)
    else $error("output position ahead of input position");

  // Bank reads must not overwrite window data that is still held.
  a_no_read_on_stall: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !can_c) |-> !rd_en)
    else $error("bank read while window stage is stalled");

  // The last output of an image returns all counters to the start.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (rd_en && emit_last) |=> ((p_cnt == '0) && (n_cnt == '0) && (out_col == '0)))
    else $error("counters not cleared after the last output");

endmodule

// File: rtl/core/rgbconv_ram.sv
`timescale 1ns / 1ps

module rgbconv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a read of the address being written returns the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule
